@@ sv/mwm_pkg.sv @@
// Shared constants and types of the multichannel window median block.
`default_nettype none

package mwm_pkg;

    // Fixed field widths of the input and result beats.
    localparam int CH_W  = 3;
    localparam int SMP_W = 8;

    // Position field width that covers the largest supported window (64 entries).
    localparam int POS_W = 6;

    // Default sizing of the block.
    localparam int CHANNELS_DEF    = 6;
    localparam int WINDOW_DEF      = 20;
    localparam int MEDIAN_RANK_DEF = 10;

    // Depth of the job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // One classified job handed from the front part to the back part.
    typedef struct packed {
        logic             in_range;
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
        logic [POS_W-1:0] pos;
    } t_job;

endpackage

`default_nettype wire

@@ sv/mwm_if.sv @@
// Valid/ready channel interfaces for sample input beats and median result beats.
`default_nettype none

interface mwm_in_if;
    logic                       valid;
    logic                       ready;
    logic [mwm_pkg::CH_W-1:0]   channel;
    logic [mwm_pkg::SMP_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mwm_out_if;
    logic                       valid;
    logic                       ready;
    logic [mwm_pkg::CH_W-1:0]   channel_out;
    logic [mwm_pkg::SMP_W-1:0]  median;

    modport source (output valid, output channel_out, output median, input ready);
    modport sink   (input valid, input channel_out, input median, output ready);
endinterface

`default_nettype wire

@@ sv/multichannel_window_median_top.sv @@
// Top level of the multichannel sliding-window median filter.
//
//   Port    Direction  Beat contents          Handshake
//   i_in    in         channel, sample        valid/ready
//   o_res   out        channel_out, median    valid/ready
//
// An in-range beat passes through these steps in the back part: pop and write the sample,
// issue WINDOW reads through the single store read port, insert the last read into the
// sorted register row, leave the read loop and load the result register.
// A beat with a channel of CHANNELS or more skips the reads and returns a zero median.
// After reset the store is cleared one entry a cycle, all CHANNELS * WINDOW entries
// (120 with the defaults), while input ready stays low.
// A two-entry queue lets the front accept beats while the back works or waits on o_res.
`default_nettype none

module multichannel_window_median_top #(
    parameter int CHANNELS    = mwm_pkg::CHANNELS_DEF,
    parameter int WINDOW      = mwm_pkg::WINDOW_DEF,
    parameter int MEDIAN_RANK = mwm_pkg::MEDIAN_RANK_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mwm_in_if.sink    i_in,
    mwm_out_if.source o_res
);

    localparam int QCNT_W = $clog2(mwm_pkg::QUEUE_DEPTH + 1);

    logic               w_push;
    logic               w_pop;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_clear_busy;
    logic [QCNT_W-1:0]  w_q_count;
    mwm_pkg::t_job      w_job_in;
    mwm_pkg::t_job      w_job_out;

    // Accept and classify.
    mwm_front #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_q_full     (w_q_full),
        .i_clear_busy (w_clear_busy),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    // Job queue.
    mwm_queue #(
        .DEPTH (mwm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    // Store and rank.
    mwm_back #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .MEDIAN_RANK (MEDIAN_RANK)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_q_empty),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_clear_busy (w_clear_busy),
        .o_res        (o_res)
    );

    // The queue never holds more jobs than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_q_count) <= 32'(mwm_pkg::QUEUE_DEPTH))
        else $error("job queue count exceeds its depth");

    // No beat is taken while the store is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear_busy |-> !i_in.ready)
        else $error("input accepted during the clearing pass");

    // The back part never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("pop from an empty job queue");

    // A result for a channel out of range carries a zero median.
    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (32'(o_res.channel_out) >= 32'(CHANNELS))) |-> (o_res.median == '0))
        else $error("nonzero median for a channel out of range");

endmodule

`default_nettype wire

@@ sv/mwm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 120
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/mwm_front.sv @@
// Front part: accepts sample beats, checks the channel and tracks the shared write position.
`default_nettype none

module mwm_front #(
    parameter int CHANNELS = mwm_pkg::CHANNELS_DEF,
    parameter int WINDOW   = mwm_pkg::WINDOW_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mwm_in_if.sink      i_in,
    input  wire logic   i_q_full,
    input  wire logic   i_clear_busy,
    output logic        o_push,
    output mwm_pkg::t_job o_job
);

    localparam int PW = $clog2(WINDOW);

    logic [PW-1:0] r_wpos;
    logic [PW-1:0] n_wpos;
    logic          w_in_range;
    logic          w_last_ch;

    // Take a beat whenever the queue has room and the store is not being cleared.
    assign i_in.ready = !i_q_full && !i_clear_busy;
    assign o_push     = i_in.valid && i_in.ready;

    assign w_in_range = 32'(i_in.channel) < 32'(CHANNELS);
    assign w_last_ch  = 32'(i_in.channel) == 32'(CHANNELS - 1);

    // Classified job for the back part.
    always_comb begin
        o_job.in_range = w_in_range;
        o_job.channel  = i_in.channel;
        o_job.sample   = i_in.sample;
        o_job.pos      = mwm_pkg::POS_W'(r_wpos);
    end

    // The shared position moves on only after a beat for the last channel.
    always_comb begin
        n_wpos = r_wpos;
        if (o_push && w_last_ch) begin
            if (r_wpos == PW'(WINDOW - 1)) begin
                n_wpos = '0;
            end else begin
                n_wpos = r_wpos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
        end else begin
            r_wpos <= n_wpos;
        end
    end

endmodule

`default_nettype wire

@@ sv/mwm_queue.sv @@
// Short job queue that decouples the front part from the back part.
`default_nettype none

module mwm_queue #(
    parameter int DEPTH = mwm_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire mwm_pkg::t_job              i_job,
    input  wire logic                       i_pop,
    output mwm_pkg::t_job                   o_job,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwm_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_count = r_count;
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/mwm_back.sv @@
// Back part: clears the window store, writes samples and ranks a channel's window.
`default_nettype none

module mwm_back #(
    parameter int CHANNELS    = mwm_pkg::CHANNELS_DEF,
    parameter int WINDOW      = mwm_pkg::WINDOW_DEF,
    parameter int MEDIAN_RANK = mwm_pkg::MEDIAN_RANK_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire mwm_pkg::t_job  i_job,
    output logic                o_pop,
    output logic                o_clear_busy,
    mwm_out_if.source           o_res
);

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int RANK  = (MEDIAN_RANK >= WINDOW) ? WINDOW - 1 : MEDIAN_RANK;
    localparam logic [AW-1:0] WIN_A = AW'(WINDOW);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                     r_state,     n_state;
    logic [AW-1:0]              r_clr_addr,  n_clr_addr;
    mwm_pkg::t_job              r_job,       n_job;
    logic [CW-1:0]              r_rd_cnt,    n_rd_cnt;
    logic                       r_rd_vld,    n_rd_vld;
    logic [mwm_pkg::SMP_W-1:0]  r_sorted [WINDOW];
    logic [mwm_pkg::SMP_W-1:0]  n_sorted [WINDOW];
    logic [WINDOW-1:0]          r_svld,      n_svld;
    logic                       r_out_valid, n_out_valid;
    logic [mwm_pkg::CH_W-1:0]   r_out_ch,    n_out_ch;
    logic [mwm_pkg::SMP_W-1:0]  r_out_med,   n_out_med;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [mwm_pkg::SMP_W-1:0]  w_wdata;
    logic [AW-1:0]              w_raddr;
    logic [mwm_pkg::SMP_W-1:0]  w_rdata;
    logic [WINDOW-1:0]          w_gt;
    logic [mwm_pkg::SMP_W-1:0]  w_ins_sorted [WINDOW];
    logic [WINDOW-1:0]          w_ins_svld;

    // Window store, one row of WINDOW entries per channel.
    mwm_ram #(
        .WIDTH (mwm_pkg::SMP_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // An in-range sample is written when its job leaves the queue; the clearing pass writes zeros.
    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_clear_busy = r_state == S_CLEAR;
    assign w_we         = (r_state == S_CLEAR) || (o_pop && i_job.in_range);
    assign w_waddr      = (r_state == S_CLEAR) ? r_clr_addr
                        : AW'(i_job.channel) * WIN_A + AW'(i_job.pos[PW-1:0]);
    assign w_wdata      = (r_state == S_CLEAR) ? '0 : i_job.sample;
    assign w_raddr      = AW'(r_job.channel) * WIN_A + AW'(r_rd_cnt);

    // Sorted insertion: each cell keeps its value, takes the new one or takes its neighbor's.
    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            w_gt[k] = !r_svld[k] || (r_sorted[k] > w_rdata);
        end
        w_ins_sorted[0] = w_gt[0] ? w_rdata : r_sorted[0];
        for (int k = 1; k < WINDOW; k++) begin
            if (!w_gt[k]) begin
                w_ins_sorted[k] = r_sorted[k];
            end else if (!w_gt[k-1]) begin
                w_ins_sorted[k] = w_rdata;
            end else begin
                w_ins_sorted[k] = r_sorted[k-1];
            end
        end
        w_ins_svld = r_svld | {r_svld[WINDOW-2:0], 1'b1};
    end

    // Sequencer next-state and result logic.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_job       = r_job;
        n_rd_cnt    = r_rd_cnt;
        n_rd_vld    = r_rd_vld;
        n_sorted    = r_sorted;
        n_svld      = r_svld;
        n_out_valid = r_out_valid;
        n_out_ch    = r_out_ch;
        n_out_med   = r_out_med;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    n_job    = i_job;
                    n_rd_cnt = '0;
                    n_rd_vld = 1'b0;
                    n_svld   = '0;
                    n_state  = i_job.in_range ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                // Issue one read a cycle; data returns from the store in the next cycle and is inserted.
                if (r_rd_cnt != CW'(WINDOW)) begin
                    n_rd_cnt = r_rd_cnt + CW'(1);
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = S_DONE;
                    end
                end
                if (r_rd_vld) begin
                    n_sorted = w_ins_sorted;
                    n_svld   = w_ins_svld;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = r_job.channel;
                    n_out_med   = r_job.in_range ? r_sorted[RANK] : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_cnt    <= '0;
            r_rd_vld    <= 1'b0;
            r_svld      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_cnt    <= n_rd_cnt;
            r_rd_vld    <= n_rd_vld;
            r_svld      <= n_svld;
            r_out_valid <= n_out_valid;
        end
        r_job     <= n_job;
        r_sorted  <= n_sorted;
        r_out_ch  <= n_out_ch;
        r_out_med <= n_out_med;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.channel_out = r_out_ch;
    assign o_res.median      = r_out_med;

endmodule

`default_nettype wire

@@ verif/tb_multichannel_window_median_top.sv @@
// Self-checking testbench for the multichannel sliding-window median filter.
`timescale 1ns / 100ps

module tb_multichannel_window_median_top;

    localparam int CH_W        = mwm_pkg::CH_W;
    localparam int SMP_W       = mwm_pkg::SMP_W;
    localparam int CHANNELS    = mwm_pkg::CHANNELS_DEF;
    localparam int WINDOW      = mwm_pkg::WINDOW_DEF;
    localparam int MEDIAN_RANK = mwm_pkg::MEDIAN_RANK_DEF;
    localparam int RANDOM_BEATS = 1350;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 3 * WINDOW + 10;
    // Window of cycles in which neither side idles.
    localparam int QUIET_START = 5000;
    localparam int QUIET_END   = 11000;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } t_sample_beat;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] median;
    } t_median_beat;

    logic i_clk;
    logic i_rst_n;

    mwm_in_if  in_if ();
    mwm_out_if res_if ();

    multichannel_window_median_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    t_sample_beat sample_q[$];
    t_median_beat median_q[$];

    // Predicted contents of every channel window and the shared write index.
    logic [SMP_W-1:0] win_mirror [CHANNELS][WINDOW];
    int               wr_index;

    int  cycle_count;
    int  err_count;
    logic quiet;

    assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Known values on every input from time zero, then one reset pulse.
    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.channel = '0;
        in_if.sample = '0;
        res_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Cycle counter and run timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multichannel_window_median_top test failed");
            $finish;
        end
    end

    initial cycle_count = 0;
    initial err_count = 0;

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Write an in-range sample into the mirrored window and queue the rank value it yields (zero out of range).
    task automatic predict_median(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
        logic [SMP_W-1:0] med;
        int               rank_sel;
        int               below;
        int               same;
        t_median_beat     res;
        med = '0;
        rank_sel = (MEDIAN_RANK >= WINDOW) ? WINDOW - 1 : MEDIAN_RANK;
        if (ch < CHANNELS) begin
            win_mirror[ch][wr_index] = smp;
            // An entry holds the selected rank when the rank lies within its run of equals.
            for (int i = 0; i < WINDOW; i++) begin
                below = 0;
                same = 0;
                for (int j = 0; j < WINDOW; j++) begin
                    if (win_mirror[ch][j] < win_mirror[ch][i])
                        below++;
                    else if (win_mirror[ch][j] == win_mirror[ch][i])
                        same++;
                end
                if (rank_sel >= below && rank_sel < below + same)
                    med = win_mirror[ch][i];
            end
            if (ch == CHANNELS - 1)
                wr_index = (wr_index == WINDOW - 1) ? 0 : wr_index + 1;
        end
        res.channel = ch;
        res.median = med;
        median_q.push_back(res);
    endtask

    // Predict on every accepted input beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_index = 0;
            for (int c = 0; c < CHANNELS; c++)
                for (int k = 0; k < WINDOW; k++)
                    win_mirror[c][k] = '0;
        end else if (in_if.valid && in_if.ready) begin
            predict_median(in_if.channel, in_if.sample);
        end
    end

    // Input driver: presents the next pending beat, with random gaps.
    always @(posedge i_clk) begin
        t_sample_beat nxt;
        logic         gap;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            gap = !quiet && ($urandom_range(99) < 22);
            if (sample_q.size() > 0 && !gap) begin
                nxt = sample_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.channel <= nxt.channel;
                in_if.sample <= nxt.sample;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        t_median_beat exp_res;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= quiet || ($urandom_range(99) >= 22);
            if (res_if.valid && res_if.ready) begin
                if (median_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat ch=%0d median=%0d",
                                            res_if.channel_out, res_if.median));
                end else begin
                    exp_res = median_q.pop_front();
                    if (res_if.channel_out !== exp_res.channel)
                        flag_mismatch($sformatf("channel_out got %0d, want %0d",
                                                res_if.channel_out, exp_res.channel));
                    if (res_if.median !== exp_res.median)
                        flag_mismatch($sformatf("median ch=%0d got %0d, want %0d",
                                                exp_res.channel, res_if.median,
                                                exp_res.median));
                end
            end
        end
    end

    task automatic queue_sample(input int ch, input int smp);
        t_sample_beat b;
        b.channel = ch[CH_W-1:0];
        b.sample = smp[SMP_W-1:0];
        sample_q.push_back(b);
    endtask

    // Sample values biased toward extremes and repeated levels.
    function automatic int pick_sample();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 255 : 0;
            1: return 85 * $urandom_range(3);
            default: return $urandom_range(255);
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        int queued;
        int mode;
        int ch;
        int run_len;

        // Directed beats: field extremes, out-of-range channels, repeated values.
        queue_sample(0, 255);
        queue_sample(0, 0);
        queue_sample(5, 255);
        queue_sample(6, 0);
        queue_sample(7, 255);
        queue_sample(7, 170);
        queue_sample(3, 128);
        queue_sample(2, 85);
        queue_sample(2, 85);
        queue_sample(4, 1);
        queue_sample(1, 254);
        for (int c = 0; c < CHANNELS; c++)
            queue_sample(c, 255);
        for (int c = 0; c < CHANNELS; c++)
            queue_sample(c, 200 - c);
        queue_sample(5, 0);

        // Random part: mostly full channel rounds so the write index wraps.
        queued = 0;
        while (queued < RANDOM_BEATS) begin
            mode = $urandom_range(99);
            if (mode < 70) begin
                for (int c = 0; c < CHANNELS; c++)
                    queue_sample(c, pick_sample());
                queued += CHANNELS;
            end else if (mode < 85) begin
                queue_sample($urandom_range(7), pick_sample());
                queued++;
            end else begin
                // Run on a single channel, in or out of range.
                ch = $urandom_range(7);
                run_len = $urandom_range(2, 8);
                for (int k = 0; k < run_len; k++)
                    queue_sample(ch, pick_sample());
                queued += run_len;
            end
        end

        // Wait for every beat to be taken, then for every result.
        @(posedge i_clk);
        while (sample_q.size() != 0 || in_if.valid !== 1'b0)
            @(posedge i_clk);
        while (median_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("multichannel_window_median_top test passed");
        end else begin
            $display("multichannel_window_median_top test failed");
        end
        $finish;
    end

endmodule
